// File: hdl/lpps_pkg.sv
// Shared types and constants for the LED pattern priority sequencer.
// Used by lpps_ctrl, lpps_dp and led_pattern_priority_sequencer; no dependencies.

package lpps_pkg;

	// Default size of the pattern table
	localparam int NUM_PATTERNS_DEF = 4;

	// Fixed field widths
	localparam int WORD_W    = 49;
	localparam int COUNT_W   = 3;
	localparam int MASK_W    = 4;
	localparam int OUT_IDX_W = 3;

	// Configuration register indexes
	localparam int REG_COUNT   = 0;
	localparam int REG_RECOVER = 1;
	localparam int REG_WORD0   = 2;

	// Operation codes
	localparam logic [1:0] OP_POLL     = 2'd0;
	localparam logic [1:0] OP_START    = 2'd1;
	localparam logic [1:0] OP_STOP     = 2'd2;
	localparam logic [1:0] OP_STOP_ALL = 2'd3;

	// Blink phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_ON   = 2'd1;
	localparam logic [1:0] PH_OFF  = 2'd2;

	// Pattern table read address sources
	localparam logic [1:0] RDS_ACT  = 2'd0;
	localparam logic [1:0] RDS_ID   = 2'd1;
	localparam logic [1:0] RDS_SCAN = 2'd2;

	// One pattern table entry, packed as written through the config port
	typedef struct packed {
		logic [7:0]  pri;
		logic        is_forever;
		logic [7:0]  rep;
		logic [15:0] off_ms;
		logic [15:0] on_ms;
	} pat_word_t;

	typedef struct packed {
		logic [1:0]        operation;
		logic [1:0]        pattern_id;
		logic [31:0]       now_ms;
		logic [MASK_W-1:0] eligible_mask;
	} item_word_t;

	typedef struct packed {
		logic                 led_on;
		logic [OUT_IDX_W-1:0] active_pattern;
		logic                 idle;
	} result_word_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic [1:0] rd_sel;
		logic       latch_in;
		logic       load_aw;
		logic       do_start;
		logic       do_advance;
		logic       do_end;
		logic       do_handoff;
		logic       do_preempt;
		logic       scan_init;
		logic       scan_run;
		logic       load_out;
	} ctrl_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic [1:0] op;
		logic       act_none;
		logic       rep_out;
		logic       start_ok;
		logic       stop_hit;
		logic       adv_handoff;
		logic       scan_done;
	} dp_status_t;

endpackage

// File: hdl/lpps_ctrl.sv
// Controller state machine of the LED pattern priority sequencer.
// Depends on lpps_pkg; drives lpps_dp through ctrl_cmd_t and reads dp_status_t.

module lpps_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	output logic                result_valid,
	input  logic                result_ready,
	input  lpps_pkg::dp_status_t status,
	output lpps_pkg::ctrl_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE    = 3'd0;
	localparam logic [2:0] S_RD_ACT  = 3'd1;
	localparam logic [2:0] S_RD_ID   = 3'd2;
	localparam logic [2:0] S_EXEC    = 3'd3;
	localparam logic [2:0] S_SCAN    = 3'd4;
	localparam logic [2:0] S_PRE_CHK = 3'd5;
	localparam logic [2:0] S_FIN     = 3'd6;

	logic [2:0] state_q, state_d;
	logic       pre_q, pre_d;       // current scan is a preemption check
	logic       chain_q, chain_d;   // run a preemption check after the handoff
	logic       res_vld_q;

	assign item_ready   = (state_q == S_IDLE);
	assign result_valid = res_vld_q;

	// Next state and commands
	always_comb begin
		cmd     = '0;
		state_d = state_q;
		pre_d   = pre_q;
		chain_d = chain_q;
		case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = S_RD_ACT;
				end
			end
			S_RD_ACT: begin
				cmd.rd_sel = lpps_pkg::RDS_ACT;
				state_d    = S_RD_ID;
			end
			S_RD_ID: begin
				cmd.rd_sel  = lpps_pkg::RDS_ID;
				cmd.load_aw = 1'b1;
				state_d     = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_FIN;
				case (status.op)
					lpps_pkg::OP_POLL: begin
						if (status.act_none || status.rep_out) begin
							cmd.scan_init = 1'b1;
							pre_d         = 1'b0;
							chain_d       = 1'b0;
							state_d       = S_SCAN;
						end else begin
							cmd.do_advance = 1'b1;
							if (status.adv_handoff) begin
								cmd.scan_init = 1'b1;
								pre_d         = 1'b0;
								chain_d       = 1'b1;
								state_d       = S_SCAN;
							end else begin
								state_d = S_PRE_CHK;
							end
						end
					end
					lpps_pkg::OP_START: begin
						cmd.do_start = status.start_ok;
					end
					lpps_pkg::OP_STOP: begin
						if (status.stop_hit) begin
							cmd.scan_init = 1'b1;
							pre_d         = 1'b0;
							chain_d       = 1'b0;
							state_d       = S_SCAN;
						end
					end
					lpps_pkg::OP_STOP_ALL: begin
						cmd.do_end = 1'b1;
					end
					default: begin
						state_d = S_FIN;
					end
				endcase
			end
			S_SCAN: begin
				cmd.rd_sel   = lpps_pkg::RDS_SCAN;
				cmd.scan_run = 1'b1;
				if (status.scan_done) begin
					if (pre_q) begin
						cmd.do_preempt = 1'b1;
						state_d        = S_FIN;
					end else begin
						cmd.do_handoff = 1'b1;
						state_d        = chain_q ? S_PRE_CHK : S_FIN;
					end
				end
			end
			S_PRE_CHK: begin
				if (status.act_none) begin
					state_d = S_FIN;
				end else begin
					cmd.scan_init = 1'b1;
					pre_d         = 1'b1;
					state_d       = S_SCAN;
				end
			end
			S_FIN: begin
				if (!res_vld_q || result_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// State and mode registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pre_q   <= 1'b0;
			chain_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pre_q   <= pre_d;
			chain_q <= chain_d;
		end
	end

	// Hold the result word until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (cmd.load_out) begin
			res_vld_q <= 1'b1;
		end else if (result_ready) begin
			res_vld_q <= 1'b0;
		end
	end

`ifndef ASSERT_OFF
	a_accept_reads: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready |=> state_q == S_RD_ACT)
		else $error("accepted word did not start the table read");

	a_scan_exit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_SCAN && status.scan_done |=> state_q == S_FIN || state_q == S_PRE_CHK)
		else $error("finished scan did not leave the scan state");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && !res_vld_q |=> state_q == S_IDLE && res_vld_q)
		else $error("result not posted from an empty output register");
`endif

endmodule

// File: hdl/lpps_dp.sv
// Datapath of the LED pattern priority sequencer: config registers, pattern
// table, blink state, candidate scan and result register. Depends on lpps_pkg.

module lpps_dp #(
	parameter int NUM_PATTERNS = lpps_pkg::NUM_PATTERNS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [$clog2(NUM_PATTERNS+2)-1:0]     cfg_index,
	input  logic [lpps_pkg::WORD_W-1:0]           cfg_data,
	input  lpps_pkg::item_word_t                  item_word,
	input  lpps_pkg::ctrl_cmd_t                   cmd,
	output lpps_pkg::dp_status_t                  status,
	output lpps_pkg::result_word_t                result_word
);

	localparam int IDX_W = $clog2(NUM_PATTERNS + 1);
	localparam int AW    = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
	localparam int MEM_D = 1 << AW;
	localparam int CIW   = $clog2(NUM_PATTERNS + 2);
	localparam logic [IDX_W-1:0] NONE = IDX_W'(NUM_PATTERNS);

	// Configuration
	logic [lpps_pkg::COUNT_W-1:0] count_q;
	logic [lpps_pkg::MASK_W-1:0]  rp_q;
	lpps_pkg::pat_word_t          mem [MEM_D];
	logic [MEM_D-1:0]             mem_vld_q;
	lpps_pkg::pat_word_t          rd_q;
	logic [AW-1:0]                rd_addr;
	logic                         cfg_word_hit;
	logic [AW-1:0]                cfg_addr;

	// Latched item
	logic [1:0]                  op_q;
	logic [1:0]                  id_q;
	logic [31:0]                 now_q;
	logic [lpps_pkg::MASK_W-1:0] mask_q;

	// Blink state
	logic [IDX_W-1:0]    act_q;
	logic [1:0]          phase_q;
	logic [7:0]          rep_q;
	logic [31:0]         start_q;
	logic                led_q;
	lpps_pkg::pat_word_t aw_q;

	// Candidate scan
	logic [IDX_W-1:0]    sc_q;
	logic                vld_s1;
	logic [IDX_W-1:0]    idx_s1;
	logic [IDX_W-1:0]    best_q;
	logic [8:0]          best_pri_q;
	lpps_pkg::pat_word_t best_word_q;

	lpps_pkg::result_word_t out_q;

	logic [IDX_W-1:0]            cnt_used;
	logic [lpps_pkg::MASK_W-1:0] elig;
	logic                        act_none;
	logic                        id_ok;
	logic [31:0]                 elapsed;
	logic                        on_done;
	logic                        off_done;
	logic [7:0]                  rep_dec;
	logic                        act_recov;
	logic                        adv_handoff;
	logic                        elig_s1;
	logic                        cand_s1;
	logic                        best_found;
	logic                        take_best;
	logic                        end_now;
	logic                        start_keep;

	// Decode counts and flags
	assign cnt_used = (32'(count_q) > NUM_PATTERNS) ? NONE : IDX_W'(count_q);
	assign elig     = rp_q & mask_q;
	assign act_none = (act_q == NONE);
	assign id_ok    = 32'(id_q) < 32'(cnt_used);
	assign elapsed  = now_q - start_q;
	assign on_done  = elapsed >= {16'd0, aw_q.on_ms};
	assign off_done = elapsed >= {16'd0, aw_q.off_ms};
	assign rep_dec  = (!aw_q.is_forever && rep_q != 8'd0) ? rep_q - 8'd1 : rep_q;
	assign act_recov = (32'(act_q) < lpps_pkg::MASK_W) && rp_q[act_q[1:0]]
		&& !mask_q[act_q[1:0]];
	assign adv_handoff = (phase_q == lpps_pkg::PH_OFF) && off_done
		&& ((!aw_q.is_forever && rep_dec == 8'd0) || (aw_q.is_forever && act_recov));

	assign elig_s1 = (32'(idx_s1) < lpps_pkg::MASK_W) && elig[idx_s1[1:0]];
	assign cand_s1 = vld_s1 && (idx_s1 != act_q) && elig_s1
		&& ({1'b0, rd_q.pri} < best_pri_q);

	assign best_found = (best_q != NONE);
	assign take_best  = best_found && (cmd.do_handoff
		|| (cmd.do_preempt && (best_pri_q < {1'b0, aw_q.pri})));
	assign end_now    = cmd.do_end || (cmd.do_handoff && !best_found);
	assign start_keep = act_none || (act_q == IDX_W'(id_q));

	always_comb begin
		status             = '0;
		status.op          = op_q;
		status.act_none    = act_none;
		status.rep_out     = !aw_q.is_forever && (rep_q == 8'd0);
		status.start_ok    = id_ok && (act_none || rd_q.pri <= aw_q.pri);
		status.stop_hit    = id_ok && (act_q == IDX_W'(id_q));
		status.adv_handoff = adv_handoff;
		status.scan_done   = !vld_s1 && !(sc_q < cnt_used);
	end

	// Configuration registers
	assign cfg_word_hit = (32'(cfg_index) >= lpps_pkg::REG_WORD0)
		&& (32'(cfg_index) < lpps_pkg::REG_WORD0 + NUM_PATTERNS);
	assign cfg_addr = AW'(32'(cfg_index) - lpps_pkg::REG_WORD0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			rp_q      <= '0;
			mem_vld_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CIW'(lpps_pkg::REG_COUNT)) begin
				count_q <= cfg_data[lpps_pkg::COUNT_W-1:0];
			end else if (cfg_index == CIW'(lpps_pkg::REG_RECOVER)) begin
				rp_q <= cfg_data[lpps_pkg::MASK_W-1:0];
			end else if (cfg_word_hit) begin
				mem_vld_q[cfg_addr] <= 1'b1;
			end
		end
	end

	// Pattern table: one write port, one registered read port
	always_comb begin
		case (cmd.rd_sel)
			lpps_pkg::RDS_ACT: rd_addr = AW'(act_q);
			lpps_pkg::RDS_ID:  rd_addr = AW'(id_q);
			default:           rd_addr = AW'(sc_q);
		endcase
	end

	always_ff @(posedge clk) begin
		if (cfg_we && cfg_word_hit) begin
			mem[cfg_addr] <= cfg_data;
		end
		rd_q <= mem_vld_q[rd_addr] ? mem[rd_addr] : '0;
	end

	// Latch the accepted item
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			op_q   <= item_word.operation;
			id_q   <= item_word.pattern_id;
			now_q  <= item_word.now_ms;
			mask_q <= item_word.eligible_mask;
		end
	end

	// Blink state: start, advance, handoff, preempt, stop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q   <= NONE;
			phase_q <= lpps_pkg::PH_IDLE;
			rep_q   <= '0;
			start_q <= '0;
			led_q   <= 1'b0;
		end else if (cmd.do_start) begin
			act_q   <= IDX_W'(id_q);
			rep_q   <= rd_q.rep;
			start_q <= now_q;
			phase_q <= lpps_pkg::PH_ON;
			led_q   <= (rd_q.on_ms != 16'd0) || (start_keep && led_q);
		end else if (cmd.do_advance) begin
			if (phase_q == lpps_pkg::PH_ON && on_done) begin
				start_q <= now_q;
				if (!(aw_q.off_ms == 16'd0 && aw_q.is_forever)) begin
					phase_q <= lpps_pkg::PH_OFF;
					if (aw_q.off_ms != 16'd0) begin
						led_q <= 1'b0;
					end
				end
			end else if (phase_q == lpps_pkg::PH_OFF && off_done) begin
				start_q <= now_q;
				rep_q   <= rep_dec;
				if (!adv_handoff) begin
					phase_q <= lpps_pkg::PH_ON;
					if (aw_q.on_ms != 16'd0) begin
						led_q <= 1'b1;
					end
				end
			end
		end else if (take_best) begin
			act_q   <= best_q;
			rep_q   <= best_word_q.rep;
			start_q <= now_q;
			phase_q <= lpps_pkg::PH_ON;
			led_q   <= (best_word_q.on_ms != 16'd0);
		end else if (end_now) begin
			act_q   <= NONE;
			phase_q <= lpps_pkg::PH_IDLE;
			rep_q   <= '0;
			led_q   <= 1'b0;
		end
	end

	// Active pattern word, refreshed per item and on handoff or preemption
	always_ff @(posedge clk) begin
		if (cmd.load_aw) begin
			aw_q <= rd_q;
		end else if (take_best) begin
			aw_q <= best_word_q;
		end
	end

	// Scan the table one entry a cycle, keeping the best priority
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_q   <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_init) begin
			sc_q   <= '0;
			vld_s1 <= 1'b0;
		end else if (cmd.scan_run) begin
			if (sc_q < cnt_used) begin
				sc_q   <= sc_q + 1'b1;
				vld_s1 <= 1'b1;
			end else begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			best_q     <= NONE;
			best_pri_q <= 9'h100;
		end else if (cmd.scan_run) begin
			idx_s1 <= sc_q;
			if (cand_s1) begin
				best_q      <= idx_s1;
				best_pri_q  <= {1'b0, rd_q.pri};
				best_word_q <= rd_q;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.led_on         <= led_q;
			out_q.active_pattern <= lpps_pkg::OUT_IDX_W'(act_q);
			out_q.idle           <= act_none;
		end
	end

	assign result_word = out_q;

`ifndef ASSERT_OFF
	a_none_is_dark: assert property (@(posedge clk) disable iff (!arst_n)
		act_q == NONE |-> phase_q == lpps_pkg::PH_IDLE && !led_q && rep_q == 8'd0)
		else $error("no active pattern but blink state not cleared");

	a_active_runs: assert property (@(posedge clk) disable iff (!arst_n)
		act_q != NONE |-> act_q < NONE && phase_q != lpps_pkg::PH_IDLE)
		else $error("active pattern without a running phase");
`endif

endmodule

// File: hdl/led_pattern_priority_sequencer.sv
// LED pattern priority sequencer: one word in, one result word out per item.
// Depends on lpps_pkg, lpps_ctrl, lpps_dp.
//
// Usage:
//   Configuration: write pattern_count (index 0), recover_present (index 1)
//   and pattern words (index 2 and up) through cfg_we/cfg_index/cfg_data
//   while no item is in flight. Pattern words read as zero until written.
//   Item channel: item_valid/item_ready carry poll, start, stop or stop-all
//   words with the current millisecond time and the eligible mask.
//   Result channel: result_valid/result_ready return the LED level, the
//   active pattern (NUM_PATTERNS when none) and an idle flag, one per item.
//   Sequence: after acceptance the block reads the active and addressed table
//   entries, runs up to two candidate scans through the table read port, each
//   over the first pattern_count entries (at most NUM_PATTERNS), then posts
//   the result. Start, stop-all and a stop that misses run no scan; a stop
//   that hits runs one; a poll runs one, or two when it hands off and then
//   checks preemption. One item at a time.
//   Reset: no pattern active, LED off, config registers zero, table invalid.
//   Stall: a result waits in the output register; the next item is accepted
//   meanwhile and its result is held back until the old one is taken.

module led_pattern_priority_sequencer #(
	parameter int NUM_PATTERNS = lpps_pkg::NUM_PATTERNS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [$clog2(NUM_PATTERNS+2)-1:0] cfg_index,
	input  logic [lpps_pkg::WORD_W-1:0]       cfg_data,
	input  logic                              item_valid,
	output logic                              item_ready,
	input  lpps_pkg::item_word_t              item_word,
	output logic                              result_valid,
	input  logic                              result_ready,
	output lpps_pkg::result_word_t            result_word
);

	lpps_pkg::ctrl_cmd_t  cmd;
	lpps_pkg::dp_status_t status;

	// Sequencer control
	lpps_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.status       (status),
		.cmd          (cmd)
	);

	// Table, blink state and scan
	lpps_dp #(
		.NUM_PATTERNS (NUM_PATTERNS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_word   (item_word),
		.cmd         (cmd),
		.status      (status),
		.result_word (result_word)
	);

endmodule
